// ----- hdl/fadd_pkg.sv -----
// package for the single-precision add/subtract block
// types and constants shared by fadd_core and float_add_sub
package fadd_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SumW  = 27;
  localparam int unsigned NormW = 26;
  localparam logic [4:0] ShiftClamp = 5'h1F;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } req_t;
endpackage

// ----- hdl/fadd_core.sv -----
// combinational add/subtract datapath: align, add, normalize, round
// depends on fadd_pkg
module fadd_core (
  input  fadd_pkg::req_t                 req,
  output logic [fadd_pkg::WordW-1:0]     sum_bits
);
  logic        sa, sb, same, a_le_b, pick_b, stk, carry, up, g, r, l;
  logic [7:0]  xa, xb, ea, eb, ehi;
  logic [8:0]  diff;
  logic [4:0]  sh;
  logic [23:0] ma, mb, mhi, mlo;
  logic [54:0] lo;
  logic [26:0] sum;
  logic [8:0]  ex;
  logic [25:0] norm, fin;
  logic [4:0]  lz;
  logic [9:0]  ef;
  logic [8:0]  eres, expo;
  logic [24:0] mres;
  logic [22:0] frac;
  logic        shi;

  always_comb begin
    sa = req.a[31];
    sb = req.b[31] ^ (req.op == fadd_pkg::OP_SUB);
    same = (sa == sb);
    xa = req.a[30:23];
    xb = req.b[30:23];
    ma = (xa == 8'd0) ? {1'b0, req.a[22:0]} : {1'b1, req.a[22:0]};
    mb = (xb == 8'd0) ? {1'b0, req.b[22:0]} : {1'b1, req.b[22:0]};
    ea = (xa == 8'd0) ? 8'd1 : xa;
    eb = (xb == 8'd0) ? 8'd1 : xb;
    a_le_b = (ea <= eb);
    diff = a_le_b ? ({1'b0, eb} - {1'b0, ea}) : ({1'b0, ea} - {1'b0, eb});
    sh = (diff > 9'd31) ? fadd_pkg::ShiftClamp : diff[4:0];
    pick_b = (sh == 5'd0) ? (ma <= mb) : a_le_b;
    mhi = pick_b ? mb : ma;
    mlo = pick_b ? ma : mb;
    ehi = pick_b ? eb : ea;
    shi = pick_b ? sb : sa;
    lo = {mlo, 31'd0} >> sh;
    stk = (lo[28:0] != 29'd0);
    sum = same ? ({1'b0, mhi, 2'b00} + {1'b0, lo[54:29]})
               : ({1'b0, mhi, 2'b00} - {1'b0, lo[54:29]});
    carry = sum[26];
    ex = carry ? ({1'b0, ehi} + 9'd1) : {1'b0, ehi};
    norm = carry ? sum[26:1] : sum[25:0];
    if (carry && sum[0]) stk = 1'b1;
    // leading-zero count over 26 bits
    lz = 5'd26;
    for (int i = 0; i < 26; i++) begin
      if (norm[i]) lz = 5'(25 - i);
    end
    ef = {1'b0, ex} - {5'd0, lz};
    if (!ef[9] && ef != 10'd0) begin
      fin = norm << lz;
      eres = ef[8:0];
    end else begin
      // stop normalizing at exponent zero
      fin = norm << (ex[5:0] - 6'd1);
      eres = 9'd0;
    end
    g = fin[1];
    r = fin[0];
    l = fin[2];
    up = (g && !r && !stk && l) || (g && !r && same && stk) || (g && r);
    mres = {1'b0, fin[25:2]} + {24'd0, up};
    if (mres[24]) begin
      expo = eres + 9'd1;
      frac = '0;
    end else if (mres[23:0] == 24'd0) begin
      expo = '0;
      frac = '0;
    end else begin
      expo = eres;
      frac = mres[22:0];
    end
    // exponent bit 8 folds into the sign
    sum_bits = {shi | expo[8], expo[7:0], frac};
  end
endmodule

// ----- hdl/float_add_sub.sv -----
// top level of the single-precision add/subtract block
// depends on fadd_pkg and fadd_core
//
// One word per cycle: start may be high every cycle (busy stays low) and the result
// appears on out_sum_bits with out_valid once it has passed the input register, the
// single-pass datapath and the result register. The receiver cannot stall; results
// must be taken when out_valid is high. NaN/inf are not special.
module float_add_sub (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [fadd_pkg::WordW-1:0]   in_operand_a,
  input  logic [fadd_pkg::WordW-1:0]   in_operand_b,
  output logic                         out_valid,
  output logic [fadd_pkg::WordW-1:0]   out_sum_bits
);
  fadd_pkg::req_t                 req_r;
  logic                           req_vld_r;
  logic [fadd_pkg::WordW-1:0]     sum_nxt, sum_r;
  logic                           vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      vld_r     <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
      vld_r     <= req_vld_r;
    end
    if (start && !busy) begin
      req_r.op <= fadd_pkg::op_t'(in_op);
      req_r.a  <= in_operand_a;
      req_r.b  <= in_operand_b;
    end
    sum_r <= sum_nxt;
  end

  fadd_core u_core (
    .req      (req_r),
    .sum_bits (sum_nxt)
  );

  assign out_valid    = vld_r;
  assign out_sum_bits = sum_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result strobe missing");
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("unexpected result strobe");
  a_xmx: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && req_r.op == fadd_pkg::OP_SUB && req_r.a == req_r.b |=>
    out_sum_bits[30:0] == 31'd0)
    else $error("x - x not zero");
endmodule

// ----- tb/tb_top.sv -----
// testbench for float_add_sub: directed and random add/subtract words
// depends on fadd_pkg and the float_add_sub rtl; scoreboard class predicts each sum

class fadd_scoreboard;
  logic [31:0] sums_q[$];
  int errors = 0;

  function automatic logic [31:0] predict_sum(logic sub, logic [31:0] a, logic [31:0] b);
    logic sa, sb, same, a_le_b, pick_b, stk, carry, up, g, r, l;
    logic [23:0] ma, mb, mhi, mlo;
    logic [7:0] ea, eb;
    logic [8:0] ehi, ex, eres, expo;
    logic [7:0] diff;
    logic [4:0] sh;
    logic [63:0] lo, sum, norm, fin;
    logic [24:0] mres;
    logic [22:0] frac;
    int lz, ef;
    sa = a[31];
    sb = b[31] ^ sub;
    same = (sa == sb);
    ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    a_le_b = (ea <= eb);
    diff = a_le_b ? eb - ea : ea - eb;
    sh = (diff > 8'd31) ? 5'd31 : diff[4:0];
    pick_b = (sh == 5'd0) ? (ma <= mb) : a_le_b;
    mhi = pick_b ? mb : ma;
    mlo = pick_b ? ma : mb;
    ehi = pick_b ? {1'b0, eb} : {1'b0, ea};
    lo = ({40'd0, mlo} << 31) >> sh;
    stk = (lo[28:0] != 29'd0);
    sum = same ? (({40'd0, mhi} << 2) + (lo >> 29)) : (({40'd0, mhi} << 2) - (lo >> 29));
    sum = sum & 64'h7FF_FFFF;
    carry = sum[26];
    ex = carry ? ehi + 9'd1 : ehi;
    norm = carry ? sum >> 1 : sum;
    if (carry && sum[0]) stk = 1'b1;
    norm = norm & 64'h3FF_FFFF;
    lz = 26;
    for (int i = 25; i >= 0; i--) begin
      if (norm[i]) begin
        lz = 25 - i;
        break;
      end
    end
    ef = int'(ex) - lz;
    if (ef > 0) begin
      fin = norm << lz;
      eres = ef[8:0];
    end else begin
      fin = norm << ((ex - 9'd1) & 9'd63);
      eres = '0;
    end
    fin = fin & 64'h3FF_FFFF;
    g = fin[1];
    r = fin[0];
    l = fin[2];
    up = (g && !r && !stk && l) || (g && !r && same && stk) || (g && r);
    mres = {1'b0, fin[25:2]} + {24'd0, up};
    if (mres[24]) begin
      expo = eres + 9'd1;
      frac = '0;
    end else if (mres[23:0] == 24'd0) begin
      expo = '0;
      frac = '0;
    end else begin
      expo = eres;
      frac = mres[22:0];
    end
    // exponent overflow spills into the sign bit
    return {pick_b ? sb : sa, 31'd0} | {expo, 23'd0} | {9'd0, frac};
  endfunction

  function void note_word(logic sub, logic [31:0] a, logic [31:0] b);
    sums_q.push_back(predict_sum(sub, a, b));
  endfunction

  function void check_sum(logic [31:0] got);
    logic [31:0] want;
    if (sums_q.size() == 0) begin
      $error("sum_bits: unexpected result %h", got);
      errors++;
    end else begin
      want = sums_q.pop_front();
      if (got !== want) begin
        $error("sum_bits: expected %h actual %h", want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_top;
  logic clk, rst_n, start, busy, in_op, out_valid;
  logic [31:0] in_operand_a, in_operand_b, out_sum_bits;
  fadd_scoreboard sb_h;

  float_add_sub dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb_h.note_word(in_op, in_operand_a, in_operand_b);
      if (out_valid) sb_h.check_sum(out_sum_bits);
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) n = 0;
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // holds the word until accepted; start stays high when the next word follows
  task automatic send_word(fadd_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    start <= 1;
    in_op <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'($urandom_range(120, 134));
      default: ;
    endcase
    return v;
  endfunction

  logic [31:0] edge_vals[10] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
    32'h3F80_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'h4B80_0001, 32'h3380_0000};

  initial begin
    logic [31:0] x;
    sb_h = new();
    rst_n = 0;
    start = 0;
    in_op = 0;
    in_operand_a = 0;
    in_operand_b = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 10; i++) begin
      send_word(fadd_pkg::OP_ADD, edge_vals[i], edge_vals[9 - i]);
      send_word(fadd_pkg::OP_SUB, edge_vals[i], edge_vals[(i + 3) % 10]);
    end
    // x - x gives negative zero; mantissa add carry case
    send_word(fadd_pkg::OP_SUB, 32'h3FC0_0000, 32'h3FC0_0000);
    send_word(fadd_pkg::OP_ADD, 32'h3FFF_FFFF, 32'h3400_0000);
    send_word(fadd_pkg::OP_ADD, 32'h7F80_0000, 32'h7F80_0000);
    start <= 0;
    while (sb_h.sums_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 700; i++) begin
      x = rand_float();
      if ($urandom_range(0, 3) == 0) send_word(fadd_pkg::op_t'($urandom_range(0, 1)), x,
        {x[31:23], x[22:0] ^ (23'd1 << $urandom_range(0, 22))});
      else send_word(fadd_pkg::op_t'($urandom_range(0, 1)), x, rand_float());
      if (i % 50 > 35) idle_gap();
    end
    start <= 0;
    while (sb_h.sums_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb_h.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end
endmodule
